@@ rtl/api_transmit_request_framer_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the transmit request framer.
// Concurrent checks are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef API_TRANSMIT_REQUEST_FRAMER_DEFINES_SVH
`define API_TRANSMIT_REQUEST_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define ATRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ATRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATRF_ASSERT(lbl, prop, msg)
`define ATRF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/atrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrf_pkg
// Types and constants shared by the transmit request framer modules.
// ----------------------------------------------------------------------------
package atrf_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int DEST_W    = 64;
  localparam int NET_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = DEST_W;
  localparam int IN_DATA_W = LEN_W + BYTE_W;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [BYTE_W-1:0] FRAME_DELIM   = 8'h7E;
  localparam logic [BYTE_W-1:0] FRAME_TYPE_TX = 8'h10;
  localparam logic [BYTE_W-1:0] CSUM_BASE     = 8'hFF;
  localparam logic [LEN_W-1:0]  LEN_OVERHEAD  = 16'd14;

  localparam logic [DEST_W-1:0] DEST_RST   = 64'h0000_0000_0000_FFFF;
  localparam logic [BYTE_W-1:0] IDENT_RST  = 8'h01;
  localparam logic [NET_W-1:0]  NET_RST    = 16'hFFFE;
  localparam logic [BYTE_W-1:0] RADIUS_RST = 8'h00;
  localparam logic [BYTE_W-1:0] OPT_RST    = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST    = 3'd0,
    CFG_IDENT   = 3'd1,
    CFG_NET     = 3'd2,
    CFG_RADIUS  = 3'd3,
    CFG_OPTIONS = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_DELIM, ST_LEN_HI, ST_LEN_LO, ST_TYPE, ST_IDENT,
    ST_DST7, ST_DST6, ST_DST5, ST_DST4, ST_DST3, ST_DST2, ST_DST1, ST_DST0,
    ST_NET_HI, ST_NET_LO, ST_RADIUS, ST_OPTIONS, ST_DATA, ST_CSUM
  } step_t;

  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic [BYTE_W-1:0] ident;
    logic [NET_W-1:0]  net;
    logic [BYTE_W-1:0] radius;
    logic [BYTE_W-1:0] options;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic              has_data;
    logic              last;
    logic [LEN_W-1:0]  len_field;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/api_transmit_request_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_transmit_request_framer
// Builds serial API transmit request frames from a stream of payload requests.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// in_      input      tdata: payload_len, data_byte; tuser: start_req
// out_     output     tdata: out_byte; tlast: frame_end
// cfg_     input      register index and write data, no read-back
//
// The single byte sequencer emits one frame byte per cycle when not stalled.
// A start request yields 18 or 19 bytes, a payload request 1 or 2 bytes.
// Requests enter at one per cycle while the command queue has room.
// Synchronous reset clears the queue and sequencer, presets the registers.
// ----------------------------------------------------------------------------
`include "api_transmit_request_framer_defines.svh"

module api_transmit_request_framer #(
  parameter int QUEUE_DEPTH = atrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Bits from low: payload_len [15:0], data_byte [23:16].
  input  logic [atrf_pkg::IN_DATA_W-1:0] in_tdata,
  // Bits from low: start_req.
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Bits from low: out_byte [7:0].
  output logic [atrf_pkg::BYTE_W-1:0]    out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [atrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [atrf_pkg::CFG_W-1:0]     cfg_wdata
);
  import atrf_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  cmd_t    push_cmd, head;
  q_stat_t q_stat;
  logic    q_push, q_pop, back_busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEST:    cfg_nxt.dest    = cfg_wdata;
        CFG_IDENT:   cfg_nxt.ident   = cfg_wdata[BYTE_W-1:0];
        CFG_NET:     cfg_nxt.net     = cfg_wdata[NET_W-1:0];
        CFG_RADIUS:  cfg_nxt.radius  = cfg_wdata[BYTE_W-1:0];
        CFG_OPTIONS: cfg_nxt.options = cfg_wdata[BYTE_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest    <= DEST_RST;
      cfg_r.ident   <= IDENT_RST;
      cfg_r.net     <= NET_RST;
      cfg_r.radius  <= RADIUS_RST;
      cfg_r.options <= OPT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  atrf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .start_req   (in_tuser),
    .payload_len (in_tdata[LEN_W-1:0]),
    .data_byte   (in_tdata[IN_DATA_W-1:LEN_W]),
    .q_stat      (q_stat),
    .push        (q_push),
    .cmd         (push_cmd)
  );

  atrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .stat     (q_stat)
  );

  atrf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .busy       (back_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .frame_end  (out_tlast)
  );

  `ATRF_ASSERT(a_no_overflow, q_push |-> !q_stat.full, "Command queue overflow.")
  `ATRF_ASSERT(a_no_underflow, q_pop |-> !q_stat.empty, "Command queue underflow.")
  `ATRF_ASSERT(a_busy_has_cmd, back_busy |-> !q_stat.empty, "Sequencer busy with no command.")

endmodule

@@ rtl/atrf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrf_front
// Accepts requests, tracks the frame position and queues byte commands.
// ----------------------------------------------------------------------------
module atrf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic                      start_req,
  input  logic [atrf_pkg::LEN_W-1:0]  payload_len,
  input  logic [atrf_pkg::BYTE_W-1:0] data_byte,
  input  atrf_pkg::q_stat_t         q_stat,
  output logic                      push,
  output atrf_pkg::cmd_t            cmd
);
  import atrf_pkg::*;

  logic             in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt;
  logic             acc;

  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    cmd.start     = start_req;
    cmd.has_data  = 1'b1;
    cmd.last      = 1'b0;
    cmd.len_field = payload_len + LEN_OVERHEAD;
    cmd.data      = data_byte;
    push          = 1'b0;
    in_frame_nxt  = in_frame_r;
    remain_nxt    = remain_r;
    priority if (acc && start_req) begin
      push = 1'b1;
      if (payload_len == '0) begin
        cmd.has_data = 1'b0;
        cmd.last     = 1'b1;
        in_frame_nxt = 1'b0;
        remain_nxt   = '0;
      end else begin
        cmd.last     = (payload_len == LEN_W'(1));
        in_frame_nxt = (payload_len != LEN_W'(1));
        remain_nxt   = payload_len - LEN_W'(1);
      end
    end else if (acc && in_frame_r) begin
      push         = 1'b1;
      cmd.last     = (remain_r == LEN_W'(1));
      in_frame_nxt = (remain_r != LEN_W'(1));
      remain_nxt   = remain_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      remain_r   <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      remain_r   <= remain_nxt;
    end
  end

endmodule

@@ rtl/atrf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrf_queue
// Small command queue between the request front and the byte sequencer.
// ----------------------------------------------------------------------------
module atrf_queue #(
  parameter int DEPTH = atrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  atrf_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output atrf_pkg::cmd_t    head,
  output atrf_pkg::q_stat_t stat
);
  import atrf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/atrf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrf_back
// Byte sequencer: expands queued commands into frame bytes and checksum.
// ----------------------------------------------------------------------------
module atrf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  atrf_pkg::cfg_t              cfg,
  input  atrf_pkg::cmd_t              head,
  input  atrf_pkg::q_stat_t           q_stat,
  output logic                        pop,
  output logic                        busy,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [atrf_pkg::BYTE_W-1:0] out_byte,
  output logic                        frame_end
);
  import atrf_pkg::*;

  step_t             step_r, step_nxt, cur_step, next_step;
  logic              busy_r, busy_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [BYTE_W-1:0] cur_byte;
  logic              summed, done, emit;

  assign cur_step = busy_r ? step_r : (head.start ? ST_DELIM : ST_DATA);
  assign emit     = !q_stat.empty && (!valid_r || out_tready);

  always_comb begin
    summed   = 1'b1;
    cur_byte = '0;
    unique case (cur_step)
      ST_DELIM:   begin cur_byte = FRAME_DELIM; summed = 1'b0; end
      ST_LEN_HI:  begin cur_byte = head.len_field[15:8]; summed = 1'b0; end
      ST_LEN_LO:  begin cur_byte = head.len_field[7:0]; summed = 1'b0; end
      ST_TYPE:    cur_byte = FRAME_TYPE_TX;
      ST_IDENT:   cur_byte = cfg.ident;
      ST_DST7:    cur_byte = cfg.dest[63:56];
      ST_DST6:    cur_byte = cfg.dest[55:48];
      ST_DST5:    cur_byte = cfg.dest[47:40];
      ST_DST4:    cur_byte = cfg.dest[39:32];
      ST_DST3:    cur_byte = cfg.dest[31:24];
      ST_DST2:    cur_byte = cfg.dest[23:16];
      ST_DST1:    cur_byte = cfg.dest[15:8];
      ST_DST0:    cur_byte = cfg.dest[7:0];
      ST_NET_HI:  cur_byte = cfg.net[15:8];
      ST_NET_LO:  cur_byte = cfg.net[7:0];
      ST_RADIUS:  cur_byte = cfg.radius;
      ST_OPTIONS: cur_byte = cfg.options;
      ST_DATA:    cur_byte = head.data;
      ST_CSUM:    begin cur_byte = CSUM_BASE - sum_r; summed = 1'b0; end
      default:    summed = 1'b0;
    endcase
  end

  always_comb begin
    done      = 1'b0;
    next_step = cur_step;
    unique case (cur_step)
      ST_OPTIONS: begin
        if (head.has_data) begin
          next_step = ST_DATA;
        end else if (head.last) begin
          next_step = ST_CSUM;
        end else begin
          done = 1'b1;
        end
      end
      ST_DATA: begin
        if (head.last) begin
          next_step = ST_CSUM;
        end else begin
          done = 1'b1;
        end
      end
      ST_CSUM: done = 1'b1;
      default: next_step = step_t'(cur_step + 5'd1);
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    step_nxt  = step_r;
    sum_nxt   = sum_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (emit) begin
      valid_nxt = 1'b1;
      byte_nxt  = cur_byte;
      last_nxt  = (cur_step == ST_CSUM);
      if (cur_step == ST_DELIM || cur_step == ST_CSUM) begin
        sum_nxt = '0;
      end else if (summed) begin
        sum_nxt = sum_r + cur_byte;
      end
      if (done) begin
        pop      = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        step_nxt = next_step;
      end
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      step_r  <= ST_DELIM;
      sum_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      step_r  <= step_nxt;
      sum_r   <= sum_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign busy       = busy_r;
  assign out_tvalid = valid_r;
  assign out_byte   = byte_r;
  assign frame_end  = last_r;

endmodule
